/* src/assert_macros.svh */
// Assertion macros for the RTL of the UTF-8 sanitizer, used by utf8_sanitizer.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition holds on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  `ASSERT_CLK(label, cond, msg)

`endif

/* src/utf8s_pkg.sv */
// Shared types, constants and lookup functions of the UTF-8 sanitizer.
// Used by utf8s_decode, utf8s_outbuf and utf8_sanitizer; depends on nothing.
package utf8s_pkg;

  // Widths of the automaton state, the code point accumulator and the result count, and the result byte limit
  localparam int STATE_W = 4;
  localparam int ACC_W   = 21;
  localparam int MAX_OUT = 6;
  localparam int CNT_W   = 3;

  // Automaton states with a fixed meaning
  localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
  localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;
  localparam logic [STATE_W-1:0] ST_LAST   = 4'd8;

  // Byte classes
  localparam logic [3:0] CLS_ASCII    = 4'd0;
  localparam logic [3:0] CLS_CONT_LO  = 4'd1;
  localparam logic [3:0] CLS_LEAD2    = 4'd2;
  localparam logic [3:0] CLS_LEAD3    = 4'd3;
  localparam logic [3:0] CLS_ED       = 4'd4;
  localparam logic [3:0] CLS_F4       = 4'd5;
  localparam logic [3:0] CLS_LEAD4    = 4'd6;
  localparam logic [3:0] CLS_CONT_HI  = 4'd7;
  localparam logic [3:0] CLS_INVALID  = 4'd8;
  localparam logic [3:0] CLS_CONT_MID = 4'd9;
  localparam logic [3:0] CLS_E0       = 4'd10;
  localparam logic [3:0] CLS_F0       = 4'd11;

  // Replacement character U+FFFD in UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Next state by [state][byte class]
  localparam logic [STATE_W-1:0] NEXT_TBL [9][12] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
    '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
    '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
  };

  // Input request and result byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Result of one request: bytes in order, byte 0 first
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [CNT_W-1:0]        cnt;
  } res_t;

  // Decoder outcome: new automaton state, accumulator and result bytes
  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [ACC_W-1:0]   accum;
    res_t               res;
  } dec_t;

  // Classify a raw byte
  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] cls;
    if (b < 8'h80)       cls = CLS_ASCII;
    else if (b < 8'h90)  cls = CLS_CONT_LO;
    else if (b < 8'hA0)  cls = CLS_CONT_MID;
    else if (b < 8'hC0)  cls = CLS_CONT_HI;
    else if (b < 8'hC2)  cls = CLS_INVALID;
    else if (b < 8'hE0)  cls = CLS_LEAD2;
    else if (b == 8'hE0) cls = CLS_E0;
    else if (b == 8'hED) cls = CLS_ED;
    else if (b < 8'hF0)  cls = CLS_LEAD3;
    else if (b == 8'hF0) cls = CLS_F0;
    else if (b < 8'hF4)  cls = CLS_LEAD4;
    else if (b == 8'hF4) cls = CLS_F4;
    else                 cls = CLS_INVALID;
    return cls;
  endfunction

  // Payload bits of a byte taken from the accept state
  function automatic logic [ACC_W-1:0] lead_bits(input logic [7:0] b, input logic [3:0] cls);
    logic [7:0] m;
    m = 8'hFF >> cls;
    return {{(ACC_W-8){1'b0}}, m & b};
  endfunction

endpackage

/* src/utf8_sanitizer.sv */
// UTF-8 sanitizer: validates a byte stream, passes well-formed characters through
// (re-encoded), drops NUL, and replaces each malformed sequence with EF BF BD.
// A request is taken into an input register; the automaton step runs on the held
// request, and when the result register is free its zero to six result bytes land
// there, and it sends one byte per cycle on out_ while out_ready is high. Plain
// ASCII streams at one byte per cycle while out_ready is high, and a longer
// result holds off requests while the single-byte output port drains it.
// No clearing pass.
// Depends on utf8s_pkg, utf8s_decode, utf8s_outbuf and assert_macros.svh.
`include "assert_macros.svh"

module utf8_sanitizer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  utf8s_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utf8s_pkg::out_item_t out_data
);

  logic                          in_vld_r, in_vld_nxt;
  utf8s_pkg::in_item_t           in_item_r, in_item_nxt;
  logic [utf8s_pkg::STATE_W-1:0] state_r, state_nxt;
  logic [utf8s_pkg::ACC_W-1:0]   accum_r, accum_nxt;
  utf8s_pkg::dec_t               dec;
  logic                          buf_free;
  logic                          load;

  // Automaton step on the held request
  utf8s_decode u_decode (
    .state (state_r),
    .accum (accum_r),
    .item  (in_item_r),
    .dec   (dec)
  );

  utf8s_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res       (dec.res),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Move the held request into the result register when it frees up
  always_comb begin
    load        = in_vld_r && buf_free;
    in_ready    = !in_vld_r || load;
    in_vld_nxt  = in_vld_r;
    in_item_nxt = in_item_r;
    state_nxt   = state_r;
    accum_nxt   = accum_r;
    if (in_valid && in_ready) begin
      in_vld_nxt  = 1'b1;
      in_item_nxt = in_data;
    end else if (load) begin
      in_vld_nxt  = 1'b0;
    end
    if (load) begin
      state_nxt = dec.state;
      accum_nxt = dec.accum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      state_r  <= utf8s_pkg::ST_ACCEPT;
      accum_r  <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      state_r  <= state_nxt;
      accum_r  <= accum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_item_r <= in_item_nxt;
  end

  // A held request that cannot load stays put
  `ASSERT_CLK(a_hold_req, in_vld_r && !buf_free |=> in_vld_r && $stable(in_item_r), "held request lost")
  // Reject is never a resting state
  `ASSERT_ALWAYS(a_no_reject, state_r != utf8s_pkg::ST_REJECT, "automaton resting in reject")
  // Six result bytes only come from a double reject, which ends in accept
  `ASSERT_CLK(a_six_accept, load && dec.res.cnt == 3'd6 |-> dec.state == utf8s_pkg::ST_ACCEPT, "six bytes without accept")
  // After the last byte leaves with nothing loaded, the output goes quiet
  `ASSERT_CLK(a_run_end, out_valid && out_ready && out_data.last_of_run && !load |=> !out_valid, "bytes beyond last of run")

endmodule

/* src/utf8s_decode.sv */
// Combinational step of the UTF-8 automaton for one request: classify, advance,
// re-encode a finished code point and build the list of result bytes.
// Depends on utf8s_pkg.
module utf8s_decode (
  input  logic [utf8s_pkg::STATE_W-1:0] state,
  input  logic [utf8s_pkg::ACC_W-1:0]   accum,
  input  utf8s_pkg::in_item_t           item,
  output utf8s_pkg::dec_t               dec
);

  logic [7:0]                    b;
  logic [utf8s_pkg::STATE_W-1:0] prev;
  logic [3:0]                    cls;
  logic [utf8s_pkg::ACC_W-1:0]   acc1;
  logic [utf8s_pkg::ACC_W-1:0]   acc2;
  logic [utf8s_pkg::STATE_W-1:0] nxt1;
  logic [utf8s_pkg::STATE_W-1:0] nxt2;
  logic [3:0][7:0]               enc;
  logic [utf8s_pkg::CNT_W-1:0]   enc_n;

  // First pass from the current state
  always_comb begin
    b    = item.end_of_input ? 8'h00 : item.data_byte;
    prev = (state > utf8s_pkg::ST_LAST) ? utf8s_pkg::ST_REJECT : state;
    cls  = utf8s_pkg::byte_class(b);
    if (prev != utf8s_pkg::ST_ACCEPT) begin
      acc1 = {accum[utf8s_pkg::ACC_W-7:0], b[5:0]};
    end else begin
      acc1 = utf8s_pkg::lead_bits(b, cls);
    end
    nxt1 = utf8s_pkg::NEXT_TBL[prev][cls];
    // Second pass of the same byte, always from accept
    acc2 = utf8s_pkg::lead_bits(b, cls);
    nxt2 = utf8s_pkg::NEXT_TBL[utf8s_pkg::ST_ACCEPT][cls];
  end

  // Re-encode the finished code point
  always_comb begin
    enc = '0;
    if (acc1 <= 21'h7F) begin
      enc[0] = acc1[7:0];
      enc_n  = 3'd1;
    end else if (acc1 <= 21'h7FF) begin
      enc[0] = 8'hC0 | {3'b000, acc1[10:6]};
      enc[1] = 8'h80 | {2'b00, acc1[5:0]};
      enc_n  = 3'd2;
    end else if (acc1 <= 21'hFFFF) begin
      enc[0] = 8'hE0 | {4'h0, acc1[15:12]};
      enc[1] = 8'h80 | {2'b00, acc1[11:6]};
      enc[2] = 8'h80 | {2'b00, acc1[5:0]};
      enc_n  = 3'd3;
    end else if (acc1 <= 21'h10FFFF) begin
      enc[0] = 8'hF0 | {5'h00, acc1[20:18]};
      enc[1] = 8'h80 | {2'b00, acc1[17:12]};
      enc[2] = 8'h80 | {2'b00, acc1[11:6]};
      enc[3] = 8'h80 | {2'b00, acc1[5:0]};
      enc_n  = 3'd4;
    end else begin
      enc_n  = 3'd0;
    end
  end

  // Pick the outcome: finished character, reject, or still in a sequence
  always_comb begin
    dec           = '0;
    dec.state     = nxt1;
    dec.accum     = acc1;
    if (nxt1 == utf8s_pkg::ST_ACCEPT) begin
      dec.res.bytes[3:0] = enc;
      dec.res.cnt        = (acc1 != '0) ? enc_n : 3'd0;
    end else if (nxt1 == utf8s_pkg::ST_REJECT) begin
      dec.state        = utf8s_pkg::ST_ACCEPT;
      dec.res.bytes[0] = utf8s_pkg::REPL_B0;
      dec.res.bytes[1] = utf8s_pkg::REPL_B1;
      dec.res.bytes[2] = utf8s_pkg::REPL_B2;
      dec.res.cnt      = 3'd3;
      // Mid-sequence reject: run the byte again from accept
      if (prev != utf8s_pkg::ST_ACCEPT) begin
        dec.accum = acc2;
        if (nxt2 == utf8s_pkg::ST_ACCEPT) begin
          dec.res.bytes[3] = acc2[7:0];
          dec.res.cnt      = (acc2 != '0) ? 3'd4 : 3'd3;
        end else if (nxt2 == utf8s_pkg::ST_REJECT) begin
          dec.res.bytes[3] = utf8s_pkg::REPL_B0;
          dec.res.bytes[4] = utf8s_pkg::REPL_B1;
          dec.res.bytes[5] = utf8s_pkg::REPL_B2;
          dec.res.cnt      = 3'd6;
        end else begin
          dec.state = nxt2;
        end
      end
    end else begin
      dec.res.cnt = 3'd0;
    end
  end

endmodule

/* src/utf8s_outbuf.sv */
// UTF-8 sanitizer result register: holds up to six bytes of one request and hands
// them out one per cycle as out_ready allows, marking the last. Uses utf8s_pkg.
module utf8s_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  utf8s_pkg::res_t       res,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output utf8s_pkg::out_item_t  out_data
);

  logic [utf8s_pkg::MAX_OUT-1:0][7:0] buf_r, buf_nxt;
  logic [utf8s_pkg::CNT_W-1:0]        rem_r, rem_nxt;
  logic                               pop;

  // Free for a new load when empty or once the last held byte leaves this cycle
  always_comb begin
    pop  = (rem_r != '0) && out_ready;
    free = (rem_r == '0) || ((rem_r == 3'd1) && out_ready);
  end

  // Load a new result or advance to the next byte
  always_comb begin
    buf_nxt = buf_r;
    rem_nxt = rem_r;
    if (load) begin
      buf_nxt = res.bytes;
      rem_nxt = res.cnt;
    end else if (pop) begin
      buf_nxt = {8'h00, buf_r[utf8s_pkg::MAX_OUT-1:1]};
      rem_nxt = rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign out_valid            = (rem_r != '0);
  assign out_data.out_byte    = buf_r[0];
  assign out_data.last_of_run = (rem_r == 3'd1);

endmodule
